// ----- hw/rtl/baro_comp_pkg.sv -----
// ----------------------------------------------------------------------------
// Barometer compensation package
// Types, widths and constants shared by the compensation pipeline.
// ----------------------------------------------------------------------------
package baro_comp_pkg;

  localparam int RawW    = 24;  // raw conversion words
  localparam int CoefW   = 16;  // calibration words
  localparam int ResW    = 32;  // result words
  localparam int CfgIdxW = 3;

  // Intermediate widths, sized for the full range of inputs and coefficients
  localparam int DtW    = 25;   // dT = D2 - C5*2^8
  localparam int ProdW  = 42;   // dT times a calibration word
  localparam int SqDtW  = 48;   // dT^2 (non-negative)
  localparam int AW     = 18;   // TEMP - 2000
  localparam int BW     = AW + 1;  // TEMP + 1500
  localparam int Off1W  = 36;
  localparam int Sens1W = 35;
  localparam int T2W    = 17;
  localparam int SqW    = 34;   // a^2, b^2 where used
  localparam int Off2W  = 39;
  localparam int Sens2W = 38;
  localparam int TempW  = 20;
  localparam int OffW   = 41;
  localparam int SensW  = 39;
  localparam int SensLoW = 20;  // low slice of SENS for the split product
  localparam int PartW  = 44;   // partial products of D1*SENS
  localparam int FullW  = 64;
  localparam int DiffW  = 43;

  // Fixed scheme constants
  localparam int TempRef    = 2000;
  localparam int TempLow    = -1500;
  localparam int TempLowOfs = TempRef - TempLow;
  localparam int Off2AWt    = 61;
  localparam int Off2BWt    = 15;
  localparam int Sens2AShft = 1;   // times 2
  localparam int Sens2BShft = 3;   // times 8
  localparam int RefShft    = 8;
  localparam int TempShft   = 23;
  localparam int OffBase    = 17;
  localparam int OffShft    = 6;
  localparam int SensBase   = 16;
  localparam int SensShft   = 7;
  localparam int T2Shft     = 31;
  localparam int Off2Shft   = 4;
  localparam int PresShft1  = 21;
  localparam int PresShft2  = 15;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSens     = 3'd0,
    CfgOffset   = 3'd1,
    CfgSensTemp = 3'd2,
    CfgOffTemp  = 3'd3,
    CfgRefTemp  = 3'd4,
    CfgTempSlope = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CoefW-1:0] c1;
    logic [CoefW-1:0] c2;
    logic [CoefW-1:0] c3;
    logic [CoefW-1:0] c4;
    logic [CoefW-1:0] c5;
    logic [CoefW-1:0] c6;
  } coef_t;

  typedef struct packed {
    logic [RawW-1:0] d1;
    logic [RawW-1:0] d2;
  } raw_t;

  // First-order results
  typedef struct packed {
    logic [RawW-1:0]          d1;
    logic signed [AW-1:0]     a;
    logic signed [Off1W-1:0]  off1;
    logic signed [Sens1W-1:0] sens1;
    logic [T2W-1:0]           t2;
  } first_t;

  // Second-order corrected terms
  typedef struct packed {
    logic [RawW-1:0]         d1;
    logic signed [TempW-1:0] temp;
    logic signed [OffW-1:0]  off;
    logic signed [SensW-1:0] sens;
  } corr_t;

  typedef struct packed {
    logic signed [ResW-1:0] pressure;
    logic signed [ResW-1:0] temp;
  } res_t;

endpackage

// ----- hw/rtl/baro_comp_meas_if.sv -----
// ----------------------------------------------------------------------------
// Raw measurement channel
// Valid/ready channel that carries one raw pressure/temperature pair.
// ----------------------------------------------------------------------------
interface baro_comp_meas_if import baro_comp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [RawW-1:0] raw_pressure;
  logic [RawW-1:0] raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// ----- hw/rtl/baro_comp_res_if.sv -----
// ----------------------------------------------------------------------------
// Compensated result channel
// Valid/ready channel that carries compensated pressure and temperature.
// ----------------------------------------------------------------------------
interface baro_comp_res_if import baro_comp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [ResW-1:0] pressure_out;
  logic signed [ResW-1:0] temp_centideg;

  modport source (output valid, output pressure_out, output temp_centideg, input ready);
  modport sink   (input valid, input pressure_out, input temp_centideg, output ready);
endinterface

// ----- hw/rtl/baro_comp_first.sv -----
// ----------------------------------------------------------------------------
// First-order stages
// dT, the four dT products, then TEMP offset, OFF, SENS and T2.
// ----------------------------------------------------------------------------
module baro_comp_first import baro_comp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  coef_t  coef_i,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  raw_t   in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output first_t out_data_o
);

  logic [2:0] vld_q;
  logic [2:0] adv;

  logic [RawW-1:0]         d1_s0_q, d1_s1_q;
  logic signed [DtW-1:0]   dt_d, dt_q;
  logic signed [ProdW-1:0] p_temp_q, p_off_q, p_sens_q;
  logic signed [2*DtW-1:0] sq_w;
  logic [SqDtW-1:0]        p_sq_q;
  first_t                  res_d, res_q;

  // Ready chain: a stage moves when empty or when the next one moves
  assign adv[2] = !vld_q[2] || out_ready_i;
  assign adv[1] = !vld_q[1] || adv[2];
  assign adv[0] = !vld_q[0] || adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
      if (adv[2]) vld_q[2] <= vld_q[1];
    end
  end

  assign dt_d = $signed({1'b0, in_data_i.d2}) -
                $signed({1'b0, coef_i.c5, {RefShft{1'b0}}});
  assign sq_w = dt_q * dt_q;

  always_comb begin
    res_d.d1    = d1_s1_q;
    res_d.a     = p_temp_q[TempShft+AW-1:TempShft];
    res_d.off1  = $signed({{(Off1W-CoefW-OffBase){1'b0}}, coef_i.c2, {OffBase{1'b0}}}) +
                  $signed(p_off_q[OffShft+Off1W-1:OffShft]);
    res_d.sens1 = $signed({{(Sens1W-CoefW-SensBase){1'b0}}, coef_i.c1, {SensBase{1'b0}}}) +
                  $signed(p_sens_q[SensShft+Sens1W-1:SensShft]);
    res_d.t2    = p_sq_q[T2Shft+T2W-1:T2Shft];
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      d1_s0_q <= in_data_i.d1;
      dt_q    <= dt_d;
    end
    if (adv[1] && vld_q[0]) begin
      d1_s1_q  <= d1_s0_q;
      p_temp_q <= dt_q * $signed({1'b0, coef_i.c6});
      p_off_q  <= dt_q * $signed({1'b0, coef_i.c4});
      p_sens_q <= dt_q * $signed({1'b0, coef_i.c3});
      p_sq_q   <= sq_w[SqDtW-1:0];
    end
    if (adv[2] && vld_q[1]) begin
      res_q <= res_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[2];
  assign out_data_o  = res_q;

  a_first_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && adv[1]) |=> vld_q[1])
    else $error("first stage item dropped on advance");

endmodule

// ----- hw/rtl/baro_comp_second.sv -----
// ----------------------------------------------------------------------------
// Second-order stages
// Square the temperature deltas, then apply T2, OFF2 and SENS2 below 20 C.
// ----------------------------------------------------------------------------
module baro_comp_second import baro_comp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  first_t in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output corr_t  out_data_o
);

  // 61*a^2 before the shift needs headroom beyond OFF2 itself
  localparam int Off2PW = Off2W + Off2Shft;

  logic [1:0] vld_q;
  logic [1:0] adv;

  first_t                  fst_q;
  logic signed [BW-1:0]    b_w;
  logic signed [2*AW-1:0]  aa_w;
  logic signed [2*BW-1:0]  bb_w;
  logic [SqW-1:0]          aa_q, bb_q;
  logic                    lo_q, vlo_q;
  logic [Off2PW-1:0]       off2a_w;
  logic [Off2W-1:0]        off2_w;
  logic [Sens2W-1:0]       sens2_w;
  corr_t                   res_d, res_q;

  assign adv[1] = !vld_q[1] || out_ready_i;
  assign adv[0] = !vld_q[0] || adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
    end
  end

  // b = TEMP + 1500, negative exactly when TEMP is below -15.00 C
  assign b_w  = BW'(in_data_i.a) + $signed(BW'(TempLowOfs));
  assign aa_w = in_data_i.a * in_data_i.a;
  assign bb_w = b_w * b_w;

  always_comb begin
    off2a_w = Off2PW'(aa_q) * Off2PW'(Off2AWt);
    off2_w  = Off2W'(off2a_w >> Off2Shft) +
              (vlo_q ? Off2W'(bb_q) * Off2W'(Off2BWt) : '0);
    sens2_w = (Sens2W'(aa_q) << Sens2AShft) +
              (vlo_q ? (Sens2W'(bb_q) << Sens2BShft) : '0);

    res_d.d1   = fst_q.d1;
    res_d.temp = $signed(TempW'(TempRef)) + TempW'(fst_q.a) -
                 (lo_q ? $signed(TempW'(fst_q.t2)) : '0);
    res_d.off  = OffW'(fst_q.off1) -
                 (lo_q ? $signed(OffW'(off2_w)) : '0);
    res_d.sens = SensW'(fst_q.sens1) -
                 (lo_q ? $signed(SensW'(sens2_w)) : '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      fst_q <= in_data_i;
      aa_q  <= aa_w[SqW-1:0];
      bb_q  <= bb_w[SqW-1:0];
      lo_q  <= in_data_i.a[AW-1];
      vlo_q <= b_w[BW-1];
    end
    if (adv[1] && vld_q[0]) begin
      res_q <= res_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[1];
  assign out_data_o  = res_q;

  a_second_low_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[0] && vlo_q) |-> lo_q)
    else $error("very low temperature flagged without low temperature");

endmodule

// ----- hw/rtl/baro_comp_press.sv -----
// ----------------------------------------------------------------------------
// Pressure stages
// D1*SENS as two partial products, then the final shifts and OFF.
// ----------------------------------------------------------------------------
module baro_comp_press import baro_comp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  corr_t in_data_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_data_o
);

  logic [1:0] vld_q;
  logic [1:0] adv;

  logic [PartW-1:0]        pl_q;
  logic signed [PartW-1:0] ph_q;
  logic signed [OffW-1:0]  off_q;
  logic signed [TempW-1:0] temp_q;
  logic signed [FullW-1:0] prod_w;
  logic signed [DiffW-1:0] diff_w;
  res_t                    res_d, res_q;

  assign adv[1] = !vld_q[1] || out_ready_i;
  assign adv[0] = !vld_q[0] || adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= in_valid_i;
      if (adv[1]) vld_q[1] <= vld_q[0];
    end
  end

  always_comb begin
    prod_w = ($signed(FullW'(ph_q)) <<< SensLoW) +
             $signed({{(FullW-PartW){1'b0}}, pl_q});
    diff_w = $signed(prod_w[PresShft1+DiffW-1:PresShft1]) - DiffW'(off_q);
    res_d.pressure = ResW'($signed(diff_w[DiffW-1:PresShft2]));
    res_d.temp     = ResW'(temp_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv[0] && in_valid_i) begin
      pl_q   <= PartW'(in_data_i.d1) * PartW'(in_data_i.sens[SensLoW-1:0]);
      ph_q   <= $signed({1'b0, in_data_i.d1}) * $signed(in_data_i.sens[SensW-1:SensLoW]);
      off_q  <= in_data_i.off;
      temp_q <= in_data_i.temp;
    end
    if (adv[1] && vld_q[0]) begin
      res_q <= res_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = vld_q[1];
  assign out_data_o  = res_q;

endmodule

// ----- hw/rtl/baro_second_order_compensation.sv -----
// ----------------------------------------------------------------------------
// Barometer second-order compensation
// Seven-stage pipeline that turns raw D1/D2 pairs into compensated pressure
// and temperature using six calibration words.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Beat contents                         Handshake
//  meas_i    in   raw_pressure, raw_temperature (24b)   valid/ready
//  comp_o    out  pressure_out, temp_centideg (32b s)   valid/ready
//  cfg_*     in   cfg_idx_i (3b), cfg_wdata_i (16b)     cfg_we_i, no stall
//
//  One beat enters per cycle while comp_o does not stall. Results leave on
//  comp_o in the order their beats were accepted; the depth is set by the
//  dT multipliers, the squaring stage and the split D1*SENS product.
//  Reset clears the calibration registers and all stage valid bits.
//  Each stage holds while the stage after it is full and stalled; empty
//  stages still fill, so meas_i keeps accepting until the pipe is full.
//  Write calibration words only while the pipe is empty.
//
module baro_second_order_compensation import baro_comp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CoefW-1:0]    cfg_wdata_i,
  baro_comp_meas_if.sink      meas_i,
  baro_comp_res_if.source     comp_o
);

  coef_t  coef_q;
  raw_t   raw_w;
  first_t first_w;
  corr_t  corr_w;
  res_t   res_w;
  logic   first_vld, first_rdy;
  logic   corr_vld, corr_rdy;

  // Calibration words; writes to unused indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgSens:      coef_q.c1 <= cfg_wdata_i;
        CfgOffset:    coef_q.c2 <= cfg_wdata_i;
        CfgSensTemp:  coef_q.c3 <= cfg_wdata_i;
        CfgOffTemp:   coef_q.c4 <= cfg_wdata_i;
        CfgRefTemp:   coef_q.c5 <= cfg_wdata_i;
        CfgTempSlope: coef_q.c6 <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign raw_w.d1 = meas_i.raw_pressure;
  assign raw_w.d2 = meas_i.raw_temperature;

  // Stages 1-3: dT, dT products, first-order terms
  baro_comp_first u_first (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coef_i      (coef_q),
    .in_valid_i  (meas_i.valid),
    .in_ready_o  (meas_i.ready),
    .in_data_i   (raw_w),
    .out_valid_o (first_vld),
    .out_ready_i (first_rdy),
    .out_data_o  (first_w)
  );

  // Stages 4-5: squares and low-temperature correction
  baro_comp_second u_second (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (first_vld),
    .in_ready_o  (first_rdy),
    .in_data_i   (first_w),
    .out_valid_o (corr_vld),
    .out_ready_i (corr_rdy),
    .out_data_o  (corr_w)
  );

  // Stages 6-7: pressure product and output register
  baro_comp_press u_press (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (corr_vld),
    .in_ready_o  (corr_rdy),
    .in_data_i   (corr_w),
    .out_valid_o (comp_o.valid),
    .out_ready_i (comp_o.ready),
    .out_data_o  (res_w)
  );

  assign comp_o.pressure_out  = res_w.pressure;
  assign comp_o.temp_centideg = res_w.temp;

  // With comp_o ready throughout, an accepted beat shows up on comp_o
  a_top_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (meas_i.valid && meas_i.ready ##1 comp_o.ready ##1 comp_o.ready ##1 comp_o.ready
     ##1 comp_o.ready ##1 comp_o.ready ##1 comp_o.ready) |=> comp_o.valid)
    else $error("result missing seven cycles after accept");

endmodule

// ----- tb/tb_baro_second_order_compensation.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the barometer second-order compensation pipeline
// Drives raw D1/D2 pairs through randomly idling valid/ready channels under
// several calibration settings and checks every compensated beat against its
// pinned value or an in-bench integer model of the compensation.
// ----------------------------------------------------------------------------
module tb_baro_second_order_compensation;
  import baro_comp_pkg::*;

  localparam int HalfPeriod    = 6;     // 12 ns clock
  localparam int ResetCycles   = 5;
  localparam int NumCal        = 6;     // calibration words C1..C6
  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 130;
  localparam int DrainCycles   = 16;    // pipe is seven deep; allow slack
  localparam int QuietLimit    = 2000;  // cycles with no beat on either channel

  // Register indexes past the last calibration word; writes there are dropped
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;

  // Directed script: a row is either a calibration write or one raw pair.
  // Pinned rows carry their expected beat; the rest go through the model.
  typedef struct packed {
    logic                   is_cfg;
    logic [CfgIdxW-1:0]     idx;
    logic [CoefW-1:0]       word;
    logic [RawW-1:0]        d1;
    logic [RawW-1:0]        d2;
    logic                   pinned;
    logic signed [ResW-1:0] pres_exp;
    logic signed [ResW-1:0] temp_exp;
  } script_row_t;

  localparam int NumRows = 21;
  localparam script_row_t Script [NumRows] = '{
    // Zero calibration after reset: dT*C6 vanishes, so TEMP sits at 20.00 C
    // and OFF = SENS = 0, which leaves zero pressure for any raw pair.
    '{1'b0, CfgSens, 16'd0, 24'd0,        24'd0,        1'b1, 32'sd0, 32'sd2000},
    '{1'b0, CfgSens, 16'd0, 24'hFFFFFF,   24'hFFFFFF,   1'b1, 32'sd0, 32'sd2000},
    '{1'b0, CfgSens, 16'd0, 24'hFFFFFF,   24'd0,        1'b1, 32'sd0, 32'sd2000},
    '{1'b0, CfgSens, 16'd0, 24'd0,        24'hFFFFFF,   1'b1, 32'sd0, 32'sd2000},
    // Typical calibration words
    '{1'b1, CfgSens,      16'd46372, 24'd0, 24'd0, 1'b0, 32'sd0, 32'sd0},
    '{1'b1, CfgOffset,    16'd43981, 24'd0, 24'd0, 1'b0, 32'sd0, 32'sd0},
    '{1'b1, CfgSensTemp,  16'd29059, 24'd0, 24'd0, 1'b0, 32'sd0, 32'sd0},
    '{1'b1, CfgOffTemp,   16'd27842, 24'd0, 24'd0, 1'b0, 32'sd0, 32'sd0},
    '{1'b1, CfgRefTemp,   16'd31553, 24'd0, 24'd0, 1'b0, 32'sd0, 32'sd0},
    '{1'b1, CfgTempSlope, 16'd28165, 24'd0, 24'd0, 1'b0, 32'sd0, 32'sd0},
    // Spare indexes must leave the calibration untouched
    '{1'b1, CfgSpareLo,   16'hFFFF,  24'd0, 24'd0, 1'b0, 32'sd0, 32'sd0},
    '{1'b1, CfgSpareHi,   16'hFFFF,  24'd0, 24'd0, 1'b0, 32'sd0, 32'sd0},
    // Room temperature, then the pressure word at both ends
    '{1'b0, CfgSens, 16'd0, 24'd6465444,  24'd8077636,  1'b0, 32'sd0, 32'sd0},
    '{1'b0, CfgSens, 16'd0, 24'd0,        24'd8077636,  1'b0, 32'sd0, 32'sd0},
    '{1'b0, CfgSens, 16'd0, 24'hFFFFFF,   24'd8077636,  1'b0, 32'sd0, 32'sd0},
    // dT = 0 sits exactly on 20.00 C; dT = -1 falls just below it
    '{1'b0, CfgSens, 16'd0, 24'd6465444,  24'd8077568,  1'b0, 32'sd0, 32'sd0},
    '{1'b0, CfgSens, 16'd0, 24'd6465444,  24'd8077567,  1'b0, 32'sd0, 32'sd0},
    // Cold but above -15.00 C, then far below it, then hot, then far below it with D1 at full scale
    '{1'b0, CfgSens, 16'd0, 24'd6465444,  24'd7800000,  1'b0, 32'sd0, 32'sd0},
    '{1'b0, CfgSens, 16'd0, 24'd6465444,  24'd0,        1'b0, 32'sd0, 32'sd0},
    '{1'b0, CfgSens, 16'd0, 24'd6465444,  24'hFFFFFF,   1'b0, 32'sd0, 32'sd0},
    '{1'b0, CfgSens, 16'd0, 24'hFFFFFF,   24'd0,        1'b0, 32'sd0, 32'sd0}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CoefW-1:0]    cfg_wdata;

  baro_comp_meas_if meas_if ();
  baro_comp_res_if  comp_if ();

  baro_second_order_compensation u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .meas_i      (meas_if),
    .comp_o      (comp_if)
  );

  // Bench copy of the calibration words, updated as each write is issued
  logic [CoefW-1:0] cal_words [NumCal];
  res_t             pending_readings [$];
  int               mismatches;
  int               quiet_cycles;
  int               stall_left;
  bit               gaps_on;
  bit               stalls_on;

  always #HalfPeriod clk = ~clk;

  // --------------------------------------------------------------------------
  // Compensation model: 64-bit signed integers throughout, every divide by a
  // power of two done as an arithmetic shift so it floors like the scheme.
  // --------------------------------------------------------------------------
  function automatic res_t compensate_pair(input logic [RawW-1:0] d1_raw,
                                           input logic [RawW-1:0] d2_raw);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, a, b, off2, sens2, pres;
    res_t   r;
    d1 = longint'(d1_raw);
    d2 = longint'(d2_raw);
    c1 = longint'(cal_words[CfgSens]);
    c2 = longint'(cal_words[CfgOffset]);
    c3 = longint'(cal_words[CfgSensTemp]);
    c4 = longint'(cal_words[CfgOffTemp]);
    c5 = longint'(cal_words[CfgRefTemp]);
    c6 = longint'(cal_words[CfgTempSlope]);

    // First order
    dt   = d2 - (c5 <<< RefShft);
    temp = TempRef + ((dt * c6) >>> TempShft);
    off  = (c2 <<< OffBase) + ((c4 * dt) >>> OffShft);
    sens = (c1 <<< SensBase) + ((c3 * dt) >>> SensShft);

    // Second order below 20.00 C, with the extra term below -15.00 C;
    // both squares use the first-order temperature
    if (temp < TempRef) begin
      a     = temp - TempRef;
      off2  = (Off2AWt * a * a) >>> Off2Shft;
      sens2 = 2 * a * a;
      if (temp < TempLow) begin
        b     = temp - TempLow;
        off2  = off2 + Off2BWt * b * b;
        sens2 = sens2 + 8 * b * b;
      end
      temp = temp - ((dt * dt) >>> T2Shft);
      off  = off - off2;
      sens = sens - sens2;
    end

    pres       = (((d1 * sens) >>> PresShft1) - off) >>> PresShft2;
    r.pressure = pres[ResW-1:0];
    r.temp     = temp[ResW-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers. The tasks drive at falling edges; send_pair returns at the
  // rising edge where its beat was taken, write_cal once cfg_we is dropped again.
  // --------------------------------------------------------------------------

  // Issue one calibration write; spare indexes are dropped by the block too
  task automatic write_cal(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] word);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= word;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (idx < NumCal) cal_words[idx] = word;
  endtask

  // Send one raw pair, maybe after a random gap, and queue its expected beat
  task automatic send_pair(input logic [RawW-1:0] d1, input logic [RawW-1:0] d2,
                           input bit pinned, input res_t pinned_reading);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      meas_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    meas_if.valid           <= 1'b1;
    meas_if.raw_pressure    <= d1;
    meas_if.raw_temperature <= d2;
    do @(posedge clk); while (!meas_if.ready);
    // Calibration is frozen while beats are in flight, so predict right here
    pending_readings.push_back(pinned ? pinned_reading : compensate_pair(d1, d2));
  endtask

  // Drop valid and hold until every queued beat has come out of the pipe
  task automatic wait_idle();
    @(negedge clk);
    meas_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Raw temperature word: mostly around the reference point C5*2^8 so the
  // cold and very cold branches get real traffic, sometimes anywhere at all
  function automatic logic [RawW-1:0] pick_raw_temp();
    longint centre, spread, v;
    if ($urandom_range(0, 3) == 0) return RawW'($urandom_range(0, 24'hFFFFFF));
    centre = longint'(cal_words[CfgRefTemp]) <<< RefShft;
    case ($urandom_range(0, 2))
      0:       spread = 64'd1 << 10;
      1:       spread = 64'd1 << 16;
      default: spread = 64'd1 << 22;
    endcase
    v = centre - spread + longint'($urandom_range(0, 32'(2 * spread)));
    if (v < 0) v = 0;
    if (v > 64'hFFFFFF) v = 64'hFFFFFF;
    return v[RawW-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Result side: stall comp_o in random bursts of clock cycles
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left != 0) begin
      comp_if.ready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      comp_if.ready <= 1'b0;
      stall_left    <= $urandom_range(0, 15);
    end else begin
      comp_if.ready <= 1'b1;
    end
  end

  // Compare each result beat with the oldest pending reading
  always @(posedge clk) begin
    res_t want;
    if (comp_if.valid && comp_if.ready) begin
      if (pending_readings.size() == 0) begin
        $error("comp_o beat with no reading pending: pressure_out %0d temp_centideg %0d",
               comp_if.pressure_out, comp_if.temp_centideg);
        mismatches++;
      end else begin
        want = pending_readings.pop_front();
        if (comp_if.pressure_out !== want.pressure) begin
          $error("pressure_out: expected %0d, got %0d", want.pressure, comp_if.pressure_out);
          mismatches++;
        end
        if (comp_if.temp_centideg !== want.temp) begin
          $error("temp_centideg: expected %0d, got %0d", want.temp, comp_if.temp_centideg);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run once neither channel has moved for too long
  always @(posedge clk) begin
    if ((meas_if.valid && meas_if.ready) || (comp_if.valid && comp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CoefW-1:0] word;
    res_t             pinned_reading;

    // Known values on every input from time zero; reset words are all zero
    clk                     = 1'b0;
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_idx                 = CfgSens;
    cfg_wdata               = '0;
    meas_if.valid           = 1'b0;
    meas_if.raw_pressure    = '0;
    meas_if.raw_temperature = '0;
    comp_if.ready           = 1'b0;
    stall_left              = 0;
    mismatches              = 0;
    quiet_cycles            = 0;
    gaps_on                 = 1'b1;
    stalls_on               = 1'b1;
    foreach (cal_words[i]) cal_words[i] = '0;

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; a calibration write first lets the pipe run dry
    for (int r = 0; r < NumRows; r++) begin
      if (Script[r].is_cfg) begin
        wait_idle();
        write_cal(Script[r].idx, Script[r].word);
      end else begin
        pinned_reading.pressure = Script[r].pres_exp;
        pinned_reading.temp     = Script[r].temp_exp;
        send_pair(Script[r].d1, Script[r].d2, Script[r].pinned, pinned_reading);
      end
    end

    // Random phases: all words at full scale, all zero, then random sets.
    // Idling is mostly on, off for some phases, and off in the last one.
    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      for (int i = 0; i < NumCal; i++) begin
        if (ph == 0)      word = 16'hFFFF;
        else if (ph == 1) word = 16'h0000;
        else              word = CoefW'($urandom_range(0, 16'hFFFF));
        write_cal(CfgIdxW'(i), word);
      end
      if (ph == NumPhases - 1) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = (ph < 2) || ($urandom_range(0, 3) != 0);
        stalls_on = (ph < 2) || ($urandom_range(0, 3) != 0);
      end
      repeat (ItemsPerPhase) begin
        send_pair(RawW'($urandom_range(0, 24'hFFFFFF)), pick_raw_temp(), 1'b0, '0);
      end
    end

    // Drain, then give any stray beat time to show up
    wait_idle();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/baro_comp_pkg.sv
hw/rtl/baro_comp_meas_if.sv
hw/rtl/baro_comp_res_if.sv
hw/rtl/baro_comp_first.sv
hw/rtl/baro_comp_second.sv
hw/rtl/baro_comp_press.sv
hw/rtl/baro_second_order_compensation.sv
tb/tb_baro_second_order_compensation.sv
